// ===== rtl/slc_pkg.sv =====
`timescale 1ns / 1ps
package slc_pkg;

  localparam int unsigned TYPE_COUNT_WIDTH = 16;
  localparam int unsigned POS_WIDTH = 10;
  localparam logic [POS_WIDTH-1:0] POS_MAX = 10'd1023;

  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_NUL = 8'd0;
  localparam logic [7:0] CHAR_S = 8'h53;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UF = 8'h46;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LF_HEX = 8'h66;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [3:0] TYPE_NONE = 4'd15;
  localparam logic [3:0] TYPE_S0 = 4'd0;
  localparam logic [3:0] TYPE_S1 = 4'd1;
  localparam logic [3:0] TYPE_S2 = 4'd2;
  localparam logic [3:0] TYPE_S3 = 4'd3;
  localparam logic [3:0] TYPE_S4 = 4'd4;
  localparam logic [3:0] TYPE_S7 = 4'd7;
  localparam logic [3:0] TYPE_S8 = 4'd8;
  localparam logic [3:0] TYPE_S9 = 4'd9;

  localparam logic [1:0] DOM_NONE = 2'd0;
  localparam logic [1:0] DOM_S1 = 2'd1;
  localparam logic [1:0] DOM_S2 = 2'd2;
  localparam logic [1:0] DOM_S3 = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
  } char_word_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] address;
    logic [3:0]  record_type;
    logic        header_ok;
    logic        hex_ok;
    logic        count_ok;
    logic        checksum_ok;
    logic        terminator_ok;
    logic [1:0]  dominant_type;
  } result_word_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_0) && (c <= CHAR_9);
  endfunction

  function automatic logic upper_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= CHAR_UA) && (c <= CHAR_UF));
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (is_digit(c)) begin
      d = c - CHAR_0;
    end else if ((c >= CHAR_UA) && (c <= CHAR_UF)) begin
      d = c - CHAR_UA + 8'd10;
    end else if ((c >= CHAR_LA) && (c <= CHAR_LF_HEX)) begin
      d = c - CHAR_LA + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic logic [2:0] addr_bytes(input logic [3:0] t);
    logic [2:0] n;
    case (t)
      TYPE_S0, TYPE_S1: n = 3'd2;
      TYPE_S2: n = 3'd3;
      TYPE_S3: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/slc_stream_if.sv =====
`timescale 1ns / 1ps
interface slc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/srecord_line_checker_unit.sv =====
`timescale 1ns / 1ps
// Checks S-record text one character per word at a sustained rate of one character per
// clock. Each character updates the line state in the cycle it is taken, and any result it
// causes (a decoded data byte, one byte late, or the end-of-line status on a line feed or NUL)
// appears in the output register on the next cycle. The character input stalls only while
// that register holds a result the downstream side is not taking in the same cycle.
module srecord_line_checker_unit #(
  parameter int unsigned TYPE_COUNT_WIDTH = slc_pkg::TYPE_COUNT_WIDTH
) (
  input logic         clk,
  input logic         rst,
  slc_stream_if.sink   chars,
  slc_stream_if.source results
);

  localparam logic [TYPE_COUNT_WIDTH-1:0] CNT_MAX = {TYPE_COUNT_WIDTH{1'b1}};

  logic [slc_pkg::POS_WIDTH-1:0] char_position;
  logic                          header_seen_ok;
  logic [3:0]                    type_digit;
  logic [3:0]                    high_nibble;
  logic [7:0]                    byte_sum;
  logic [7:0]                    count_field;
  logic [31:0]                   address_accum;
  logic [7:0]                    held_byte;
  logic                          held_valid;
  logic                          hex_good;
  logic [TYPE_COUNT_WIDTH-1:0]   lines_type_one;
  logic [TYPE_COUNT_WIDTH-1:0]   lines_type_two;
  logic [TYPE_COUNT_WIDTH-1:0]   lines_type_three;

  logic                          res_valid;
  slc_pkg::result_word_t         res_word;

  logic [slc_pkg::POS_WIDTH-1:0] char_position_next;
  logic                          header_seen_ok_next;
  logic [3:0]                    type_digit_next;
  logic [3:0]                    high_nibble_next;
  logic [7:0]                    byte_sum_next;
  logic [7:0]                    count_field_next;
  logic [31:0]                   address_accum_next;
  logic [7:0]                    held_byte_next;
  logic                          held_valid_next;
  logic                          hex_good_next;
  logic [TYPE_COUNT_WIDTH-1:0]   lines_type_one_next;
  logic [TYPE_COUNT_WIDTH-1:0]   lines_type_two_next;
  logic [TYPE_COUNT_WIDTH-1:0]   lines_type_three_next;
  logic                          emit;
  slc_pkg::result_word_t         res_word_next;

  logic [7:0]                    c;
  logic                          accept;
  logic                          line_end;
  logic [3:0]                    t;
  logic [1:0]                    dom;
  logic                          term;
  logic [3:0]                    nib;
  logic [7:0]                    b;
  logic [8:0]                    k;
  logic [8:0]                    ab;
  logic [8:0]                    half_len;
  logic [slc_pkg::POS_WIDTH-1:0] p_less_two;
  logic [slc_pkg::POS_WIDTH-1:0] p_less_four;

  assign c = chars.payload.char_code;
  assign chars.ready = !res_valid || results.ready;
  assign accept = chars.valid && chars.ready;
  assign line_end = (c == slc_pkg::CHAR_LF) || (c == slc_pkg::CHAR_NUL);
  assign results.valid = res_valid;
  assign results.payload = res_word;

  assign t = (char_position >= 10'd2) ? type_digit : slc_pkg::TYPE_NONE;
  assign nib = slc_pkg::nibble_of(c);
  assign b = {high_nibble, nib};
  assign p_less_two = char_position - 10'd2;
  assign p_less_four = char_position - 10'd4;
  assign k = p_less_two[slc_pkg::POS_WIDTH-1:1];
  assign half_len = p_less_four[slc_pkg::POS_WIDTH-1:1];
  assign ab = {6'd0, slc_pkg::addr_bytes(type_digit)};

  always_comb begin
    lines_type_one_next = lines_type_one;
    lines_type_two_next = lines_type_two;
    lines_type_three_next = lines_type_three;
    if (line_end) begin
      if ((t == slc_pkg::TYPE_S1) && (lines_type_one != CNT_MAX)) begin
        lines_type_one_next = lines_type_one + 1'b1;
      end
      if ((t == slc_pkg::TYPE_S2) && (lines_type_two != CNT_MAX)) begin
        lines_type_two_next = lines_type_two + 1'b1;
      end
      if ((t == slc_pkg::TYPE_S3) && (lines_type_three != CNT_MAX)) begin
        lines_type_three_next = lines_type_three + 1'b1;
      end
    end
    if ((lines_type_one_next > lines_type_two_next) &&
        (lines_type_one_next > lines_type_three_next)) begin
      dom = slc_pkg::DOM_S1;
    end else if ((lines_type_two_next > lines_type_one_next) &&
                 (lines_type_two_next > lines_type_three_next)) begin
      dom = slc_pkg::DOM_S2;
    end else if ((lines_type_three_next > lines_type_one_next) &&
                 (lines_type_three_next > lines_type_two_next)) begin
      dom = slc_pkg::DOM_S3;
    end else begin
      dom = slc_pkg::DOM_NONE;
    end
    case (t)
      slc_pkg::TYPE_S9: term = (dom == slc_pkg::DOM_S1);
      slc_pkg::TYPE_S8: term = (dom == slc_pkg::DOM_S2);
      slc_pkg::TYPE_S7: term = (dom == slc_pkg::DOM_S3);
      default: term = 1'b1;
    endcase
  end

  always_comb begin
    char_position_next = char_position;
    header_seen_ok_next = header_seen_ok;
    type_digit_next = type_digit;
    high_nibble_next = high_nibble;
    byte_sum_next = byte_sum;
    count_field_next = count_field;
    address_accum_next = address_accum;
    held_byte_next = held_byte;
    held_valid_next = held_valid;
    hex_good_next = hex_good;
    emit = 1'b0;
    res_word_next = '0;
    if (line_end) begin
      emit = 1'b1;
      res_word_next.kind = slc_pkg::KIND_STATUS;
      res_word_next.address = address_accum;
      res_word_next.record_type = t;
      res_word_next.header_ok = header_seen_ok && (t <= slc_pkg::TYPE_S9) &&
                                (t != slc_pkg::TYPE_S4);
      res_word_next.hex_ok = hex_good;
      res_word_next.count_ok = (char_position >= 10'd4) &&
                               ({1'b0, count_field} == half_len);
      res_word_next.checksum_ok = held_valid && ((8'hFF - byte_sum) == held_byte);
      res_word_next.terminator_ok = term;
      res_word_next.dominant_type = dom;
      char_position_next = '0;
      header_seen_ok_next = 1'b0;
      type_digit_next = 4'd0;
      high_nibble_next = 4'd0;
      byte_sum_next = 8'd0;
      count_field_next = 8'd0;
      address_accum_next = 32'd0;
      held_byte_next = 8'd0;
      held_valid_next = 1'b0;
      hex_good_next = 1'b1;
    end else begin
      if (char_position == 10'd0) begin
        header_seen_ok_next = (c == slc_pkg::CHAR_S);
      end else if (char_position == 10'd1) begin
        type_digit_next = slc_pkg::is_digit(c) ? nib : slc_pkg::TYPE_NONE;
      end else begin
        if (!slc_pkg::upper_hex(c)) begin
          hex_good_next = 1'b0;
        end
        if (char_position < slc_pkg::POS_MAX) begin
          if (!char_position[0]) begin
            high_nibble_next = nib;
          end else begin
            if (k == 9'd0) begin
              count_field_next = b;
            end else if (k <= ab) begin
              address_accum_next = {address_accum[23:0], b};
            end
            if (held_valid) begin
              if (k >= ab + 9'd2) begin
                emit = 1'b1;
                res_word_next.kind = slc_pkg::KIND_DATA;
                res_word_next.data_byte = held_byte;
                res_word_next.address = address_accum_next;
                res_word_next.record_type = type_digit;
              end
              byte_sum_next = byte_sum + held_byte;
            end
            held_byte_next = b;
            held_valid_next = 1'b1;
          end
        end
      end
      if (char_position < slc_pkg::POS_MAX) begin
        char_position_next = char_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      header_seen_ok <= 1'b0;
      type_digit <= 4'd0;
      high_nibble <= 4'd0;
      byte_sum <= 8'd0;
      count_field <= 8'd0;
      address_accum <= 32'd0;
      held_byte <= 8'd0;
      held_valid <= 1'b0;
      hex_good <= 1'b1;
      lines_type_one <= '0;
      lines_type_two <= '0;
      lines_type_three <= '0;
      res_valid <= 1'b0;
    end else begin
      if (accept && emit) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        char_position <= char_position_next;
        header_seen_ok <= header_seen_ok_next;
        type_digit <= type_digit_next;
        high_nibble <= high_nibble_next;
        byte_sum <= byte_sum_next;
        count_field <= count_field_next;
        address_accum <= address_accum_next;
        held_byte <= held_byte_next;
        held_valid <= held_valid_next;
        hex_good <= hex_good_next;
        lines_type_one <= lines_type_one_next;
        lines_type_two <= lines_type_two_next;
        lines_type_three <= lines_type_three_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_word <= res_word_next;
    end
  end

endmodule
